// ----- hw/rtl/kne_pkg.sv -----
`timescale 1ns / 1ps

package kne_pkg;

    localparam int unsigned COL_W   = 4;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned MAP_W   = 64;

    localparam logic [COL_W-1:0]  ALL_HIGH    = 4'hF;
    localparam logic [CODE_W-1:0] CODE_DELETE = 4'd13;
    localparam logic [CODE_W-1:0] MAX_DIGIT   = 4'd9;
    localparam logic [CNT_W-1:0]  COUNT_MAX   = 4'd15;
    localparam logic [MAP_W-1:0]  MAP_RESET   = 64'hFEDC_BA09_8765_4321;

    // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
    localparam logic [NUM_W-1:0]  RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned       RECIP_SHIFT = 35;

    typedef struct packed {
        logic [ROW_W-1:0]  row_drive;
        logic [NUM_W-1:0]  entry_value;
        logic [CNT_W-1:0]  digit_count;
        logic [CODE_W-1:0] key_code;
        logic              key_event;
        logic              entry_done;
    } t_result;

endpackage

// ----- hw/rtl/kne_if.sv -----
`timescale 1ns / 1ps

interface kne_col_if;
    import kne_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] col_sample;

    modport source (output valid, output col_sample, input ready);
    modport sink   (input valid, input col_sample, output ready);
endinterface

interface kne_res_if;
    import kne_pkg::*;
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_drive;
    logic [NUM_W-1:0]  entry_value;
    logic [CNT_W-1:0]  digit_count;
    logic [CODE_W-1:0] key_code;
    logic              key_event;
    logic              entry_done;

    modport source (output valid, output row_drive, output entry_value, output digit_count,
                    output key_code, output key_event, output entry_done, input ready);
    modport sink   (input valid, input row_drive, input entry_value, input digit_count,
                    input key_code, input key_event, input entry_done, output ready);
endinterface

interface kne_cfg_if;
    import kne_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAP_W-1:0] key_map;

    modport source (output valid, output key_map, input ready);
    modport sink   (input valid, input key_map, output ready);
endinterface

// ----- hw/rtl/kne_div10.sv -----
`timescale 1ns / 1ps

module kne_div10
    import kne_pkg::*;
(
    input  logic [NUM_W-1:0] i_num,
    output logic [NUM_W-1:0] o_quot
);

    logic [2*NUM_W-1:0] prod;

    assign prod   = {{NUM_W{1'b0}}, i_num} * {{NUM_W{1'b0}}, RECIP_TEN};
    assign o_quot = NUM_W'(prod >> RECIP_SHIFT);

endmodule

// ----- hw/rtl/kne_scan.sv -----
`timescale 1ns / 1ps

module kne_scan
    import kne_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [COL_W-1:0] i_cols,
    input  logic [MAP_W-1:0] i_key_map,
    output t_result          o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCAN,
        PH_RELEASE
    } t_phase;

    t_phase            r_phase,  n_phase;
    logic [1:0]        r_row,    n_row;
    logic [NUM_W-1:0]  r_num,    n_num;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic              r_finish, n_finish;
    t_result           r_result, n_result;

    logic [1:0]        col_idx;
    logic [3:0]        key_idx;
    logic [CODE_W-1:0] code;
    logic [NUM_W-1:0]  num_div10;
    logic [NUM_W-1:0]  num_append;

    kne_div10 u_div10 (
        .i_num  (r_num),
        .o_quot (num_div10)
    );

    always_comb begin
        // lowest low column wins; column 3 if the first three are high
        if (!i_cols[0]) begin
            col_idx = 2'd0;
        end else if (!i_cols[1]) begin
            col_idx = 2'd1;
        end else if (!i_cols[2]) begin
            col_idx = 2'd2;
        end else begin
            col_idx = 2'd3;
        end
    end

    assign key_idx    = {r_row, col_idx};
    assign code       = i_key_map[{key_idx, 2'b00} +: CODE_W];
    assign num_append = (r_num << 3) + (r_num << 1) + NUM_W'(code);

    always_comb begin
        n_phase  = r_phase;
        n_row    = r_row;
        n_num    = r_num;
        n_cnt    = r_cnt;
        n_finish = r_finish;
        n_result = '0;

        case (r_phase)
            PH_SCAN: begin
                if (i_cols != ALL_HIGH) begin
                    n_result.key_code  = code;
                    n_result.key_event = 1'b1;
                    if (code <= MAX_DIGIT) begin
                        n_num = num_append;
                        if (r_cnt < COUNT_MAX) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (code == CODE_DELETE) begin
                        n_num = num_div10;
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - 1'b1;
                        end
                    end else begin
                        n_finish = 1'b1;
                    end
                    n_phase = PH_RELEASE;
                end else if (r_row == 2'd3) begin
                    n_phase = PH_IDLE;
                    n_row   = 2'd0;
                end else begin
                    n_row              = r_row + 2'd1;
                    n_result.row_drive = ~(ROW_W'(1) << (r_row + 2'd1));
                end
                n_result.entry_value = n_num;
                n_result.digit_count = n_cnt;
            end
            PH_RELEASE: begin
                n_result.entry_value = r_num;
                n_result.digit_count = r_cnt;
                if (i_cols == ALL_HIGH) begin
                    if (r_finish) begin
                        n_result.entry_done = 1'b1;
                        n_finish = 1'b0;
                        n_num    = '0;
                        n_cnt    = '0;
                    end
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // idle, and the unused phase code behaves the same
                n_phase = PH_IDLE;
                if (i_cols != ALL_HIGH) begin
                    n_phase            = PH_SCAN;
                    n_row              = 2'd0;
                    n_result.row_drive = ~ROW_W'(1);
                end
                n_result.entry_value = r_num;
                n_result.digit_count = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_row    <= '0;
            r_num    <= '0;
            r_cnt    <= '0;
            r_finish <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_num    <= n_num;
            r_cnt    <= n_cnt;
            r_finish <= n_finish;
        end
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ----- hw/rtl/keypad_number_entry.sv -----
`timescale 1ns / 1ps

// 4x4 matrix keypad scanner that builds a decimal number from key presses.
// i_col takes one column sample per request, taken under the row drive sent
// with the previous result. o_res returns one result per sample: the row
// drive for the next tick, the number and digit count so far, the decoded
// key code with its event flag, and the entry-done pulse.
// i_cfg writes the 64-bit key map (4-bit code per key, row*4+col); it is
// always ready. The key map must be written only while the block is idle,
// a rule on the user that the block itself does not enforce. A sample passes
// through the input register and then the result register.
// Throughput: one sample per cycle while o_res is ready; the per-sample update
// (append a digit, or divide by ten through one reciprocal multiplier) is
// combinational. When o_res stalls the result register holds and i_col stays
// ready until the input register is also full; nothing is dropped.
// Synchronous reset clears both valid flags and returns the scanner to idle
// with number and count at zero and the key map at its default.
module keypad_number_entry
    import kne_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    kne_col_if.sink   i_col,
    kne_cfg_if.sink   i_cfg,
    kne_res_if.source o_res
);

    logic             r_in_valid;
    logic [COL_W-1:0] r_cols;
    logic             r_out_valid;
    logic [MAP_W-1:0] r_key_map;
    logic             step;
    t_result          result;

    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_col.ready = !r_in_valid || step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_map   <= MAP_RESET;
        end else begin
            if (i_col.ready) begin
                r_in_valid <= i_col.valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_key_map <= i_cfg.key_map;
            end
        end
        if (i_col.ready && i_col.valid) begin
            r_cols <= i_col.col_sample;
        end
    end

    kne_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_cols    (r_cols),
        .i_key_map (r_key_map),
        .o_result  (result)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.row_drive   = result.row_drive;
    assign o_res.entry_value = result.entry_value;
    assign o_res.digit_count = result.digit_count;
    assign o_res.key_code    = result.key_code;
    assign o_res.key_event   = result.key_event;
    assign o_res.entry_done  = result.entry_done;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import kne_pkg::*;

    typedef enum logic [1:0] {
        KP_IDLE    = 2'd0,
        KP_ROWS    = 2'd1,
        KP_RELEASE = 2'd2
    } kp_phase_e;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kne_col_if col_bus ();
    kne_cfg_if cfg_bus ();
    kne_res_if res_bus ();

    keypad_number_entry uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (col_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // scanner state as the block should hold it
    kp_phase_e         kp_phase;
    logic [1:0]        kp_row;
    logic [NUM_W-1:0]  kp_number;
    logic [CNT_W-1:0]  kp_digits;
    logic              kp_finish;
    logic [MAP_W-1:0]  kp_map;

    logic [COL_W-1:0]  sample_plan[$];
    t_result           readouts_due[$];

    int  faults = 0;
    int  samples_taken = 0;
    int  stall_cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  col_took = 1'b0;
    bit  hold_long = 1'b0;
    bit  calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [ROW_W-1:0] row_strobe(logic [1:0] r);
        return ~(4'b0001 << r);
    endfunction

    // one column sample through the scanner; returns what the block shows
    function automatic t_result scan_tick(logic [COL_W-1:0] cols);
        t_result r;
        int c;
        logic [CODE_W-1:0] code;
        r = '0;
        case (kp_phase)
            KP_ROWS: begin
                if (cols != ALL_HIGH) begin
                    c = 0;
                    while (c < 3 && cols[c]) c++;
                    code = kp_map[4 * (int'(kp_row) * 4 + c) +: 4];
                    r.key_code = code;
                    r.key_event = 1'b1;
                    if (code <= MAX_DIGIT) begin
                        kp_number = kp_number * 10 + NUM_W'(code);
                        if (kp_digits != COUNT_MAX) kp_digits = kp_digits + 1'b1;
                    end else if (code == CODE_DELETE) begin
                        kp_number = kp_number / 10;
                        if (kp_digits != '0) kp_digits = kp_digits - 1'b1;
                    end else begin
                        kp_finish = 1'b1;
                    end
                    kp_phase = KP_RELEASE;
                end else if (kp_row == 2'd3) begin
                    kp_phase = KP_IDLE;
                    kp_row = 2'd0;
                end else begin
                    kp_row = kp_row + 1'b1;
                    r.row_drive = row_strobe(kp_row);
                end
                r.entry_value = kp_number;
                r.digit_count = kp_digits;
            end
            KP_RELEASE: begin
                r.entry_value = kp_number;
                r.digit_count = kp_digits;
                if (cols == ALL_HIGH) begin
                    if (kp_finish) begin
                        r.entry_done = 1'b1;
                        kp_finish = 1'b0;
                        kp_number = '0;
                        kp_digits = '0;
                    end
                    kp_phase = KP_IDLE;
                end
            end
            default: begin
                kp_phase = KP_IDLE;
                if (cols != ALL_HIGH) begin
                    kp_phase = KP_ROWS;
                    kp_row = 2'd0;
                    r.row_drive = row_strobe(2'd0);
                end
                r.entry_value = kp_number;
                r.digit_count = kp_digits;
            end
        endcase
        return r;
    endfunction

    task automatic flag_field(string what, logic [NUM_W-1:0] want_v, logic [NUM_W-1:0] got_v);
        faults++;
        if (faults <= 10)
            $display("%0t: %s expected %0h, got %0h", $realtime, what, want_v, got_v);
    endtask

    // column pattern whose lowest low column is c
    function automatic logic [COL_W-1:0] low_at(int c);
        logic [COL_W-1:0] v;
        v = COL_W'($urandom_range(0, 15));
        for (int i = 0; i < c; i++) v[i] = 1'b1;
        v[c] = 1'b0;
        return v;
    endfunction

    function automatic logic [COL_W-1:0] any_low();
        return COL_W'($urandom_range(0, 14));
    endfunction

    // wake from idle, step down to the row, press, hold, let go
    task automatic queue_press(int row, logic [COL_W-1:0] pressed, int hold, inout int added);
        sample_plan.push_back(any_low());
        repeat (row) sample_plan.push_back(ALL_HIGH);
        sample_plan.push_back(pressed);
        repeat (hold) sample_plan.push_back(any_low());
        sample_plan.push_back(ALL_HIGH);
        added += row + hold + 3;
    endtask

    task automatic queue_keying(int n_samples);
        int added;
        int n;
        added = 0;
        while (added < n_samples) begin
            if ($urandom_range(0, 99) < 85) begin
                queue_press($urandom_range(0, 3), low_at($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, added);
            end else begin
                // garbage, then four highs always bring the scanner back to idle
                n = $urandom_range(1, 4);
                repeat (n) sample_plan.push_back(COL_W'($urandom_range(0, 15)));
                repeat (4) sample_plan.push_back(ALL_HIGH);
                added += n + 4;
            end
        end
    endtask

    task automatic drain();
        while (sample_plan.size() != 0 || col_bus.valid || readouts_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_key_map(logic [MAP_W-1:0] m);
        drain();
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.key_map <= m;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [MAP_W-1:0] digit_map();
        logic [MAP_W-1:0] m;
        for (int i = 0; i < 16; i++) m[4 * i +: 4] = CODE_W'($urandom_range(0, 9));
        m[4 * $urandom_range(0, 15) +: 4] = CODE_DELETE;
        m[4 * $urandom_range(0, 15) +: 4] = CODE_DELETE;
        m[4 * $urandom_range(0, 15) +: 4] = 4'd14;
        return m;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            col_bus.valid <= 1'b0;
        end else if (!col_bus.valid || col_took) begin
            if (send_gap > 0 && !calm) begin
                send_gap--;
                col_bus.valid <= 1'b0;
            end else if (sample_plan.size() == 0) begin
                col_bus.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                send_gap = $urandom_range(0, 18);
                col_bus.valid <= 1'b0;
            end else begin
                col_bus.valid <= 1'b1;
                col_bus.col_sample <= sample_plan.pop_front();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_long) begin
            res_bus.ready <= 1'b0;
        end else if (calm) begin
            res_bus.ready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            res_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            recv_gap = $urandom_range(0, 18);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        bit moved;
        col_took = 1'b0;
        moved = 1'b0;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                kp_map = cfg_bus.key_map;
                moved = 1'b1;
            end
            if (col_bus.valid && col_bus.ready) begin
                readouts_due.push_back(scan_tick(col_bus.col_sample));
                col_took = 1'b1;
                samples_taken++;
                moved = 1'b1;
            end
            if (res_bus.valid && res_bus.ready) begin
                moved = 1'b1;
                got.row_drive   = res_bus.row_drive;
                got.entry_value = res_bus.entry_value;
                got.digit_count = res_bus.digit_count;
                got.key_code    = res_bus.key_code;
                got.key_event   = res_bus.key_event;
                got.entry_done  = res_bus.entry_done;
                if (readouts_due.size() == 0) begin
                    flag_field("result with nothing outstanding, value", '0, got.entry_value);
                end else begin
                    want = readouts_due.pop_front();
                    if (got.row_drive != want.row_drive)
                        flag_field("row_drive", want.row_drive, got.row_drive);
                    if (got.entry_value != want.entry_value)
                        flag_field("entry_value", want.entry_value, got.entry_value);
                    if (got.digit_count != want.digit_count)
                        flag_field("digit_count", want.digit_count, got.digit_count);
                    if (got.key_code != want.key_code)
                        flag_field("key_code", want.key_code, got.key_code);
                    if (got.key_event != want.key_event)
                        flag_field("key_event", want.key_event, got.key_event);
                    if (got.entry_done != want.entry_done)
                        flag_field("entry_done", want.entry_done, got.entry_done);
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // long receiver hold-off so the block fills and pushes back on requests
    initial begin
        wait (samples_taken >= 60);
        @(posedge i_clk);
        hold_long = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_long = 1'b0;
    end

    initial begin
        int added;
        col_bus.valid = 1'b0;
        col_bus.col_sample = ALL_HIGH;
        cfg_bus.valid = 1'b0;
        cfg_bus.key_map = '0;
        res_bus.ready = 1'b0;
        kp_phase = KP_IDLE;
        kp_row = 2'd0;
        kp_number = '0;
        kp_digits = '0;
        kp_finish = 1'b0;
        kp_map = MAP_RESET;
        added = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // scan that finds no row
        sample_plan.push_back(4'h0);
        repeat (4) sample_plan.push_back(ALL_HIGH);
        // every column low on row 0, delete twice (second at zero), then end key
        queue_press(0, 4'h0, 0, added);
        queue_press(3, 4'b1101, 1, added);
        queue_press(3, 4'b1101, 0, added);
        queue_press(3, 4'b0111, 2, added);
        queue_keying(100);

        load_key_map({$urandom, $urandom});
        queue_keying(90);
        load_key_map('0);
        queue_keying(70);
        load_key_map('1);
        queue_keying(50);
        load_key_map(digit_map());
        queue_keying(110);

        load_key_map({$urandom, $urandom});
        calm = 1'b1;
        queue_keying(60);

        drain();
        repeat (4) @(posedge i_clk);
        if (readouts_due.size() != 0) faults++;
        if (faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
